// ===== rtl/core/ssdw_pkg.sv =====
// shared types, command codes and segment table of the display writer
package ssdw_pkg;

    localparam int NUM_DISPLAYS = 6;
    localparam int SEG_W        = 7;
    localparam int NUM_W        = 20;
    localparam int DIGIT_W      = 4;
    localparam int MULT_W       = NUM_W + 1;
    localparam int PROD_W       = NUM_W + MULT_W;

    // command codes
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_DIGIT = 3'd1;
    localparam logic [2:0] CMD_INT   = 3'd2;
    localparam logic [2:0] CMD_SCORE = 3'd3;
    localparam logic [2:0] CMD_RAW   = 3'd4;

    // operand limits
    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd10;
    localparam logic [NUM_W-1:0]   INT_LIMIT   = 20'd999999;
    localparam logic [NUM_W-1:0]   SCORE_LIMIT = 20'd999;
    localparam logic [SEG_W-1:0]   SEG_BLANK   = 7'd127;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  position;
        logic [3:0]  digit;
        logic [19:0] number;
        logic        player;
        logic [41:0] raw_patterns;
    } ssdw_in_t;

    typedef struct packed {
        logic [6:0] seg0;
        logic [6:0] seg1;
        logic [6:0] seg2;
        logic [6:0] seg3;
        logic [6:0] seg4;
        logic [6:0] seg5;
        logic       bad_operand;
    } ssdw_out_t;

    typedef logic [NUM_DISPLAYS-1:0][DIGIT_W-1:0] ssdw_digits_t;

    // active-low pattern, bit 6 = g ... bit 0 = a; blank for ten and above
    function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] code;
        case (d)
            4'd0:    code = 7'd64;
            4'd1:    code = 7'd121;
            4'd2:    code = 7'd36;
            4'd3:    code = 7'd48;
            4'd4:    code = 7'd25;
            4'd5:    code = 7'd18;
            4'd6:    code = 7'd2;
            4'd7:    code = 7'd120;
            4'd8:    code = 7'd0;
            4'd9:    code = 7'd16;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/ssdw_digit_split.sv =====
// splits a binary value into six decimal digits by reciprocal multiplication
module ssdw_digit_split
    import ssdw_pkg::*;
(
    input  logic [NUM_W-1:0] number,
    output ssdw_digits_t     digits
);

    logic [NUM_DISPLAYS-1:0][NUM_W-1:0] quot;

    assign quot[0] = number;

    // quot[k] = number / 10**k, each an independent constant multiply
    for (genvar k = 1; k < NUM_DISPLAYS; k++) begin : g_quot
        localparam longint unsigned DIV   = longint'(10) ** k;
        localparam int              SHIFT = NUM_W + $clog2(DIV);
        localparam longint unsigned MULT  = ((64'd1 << SHIFT) + DIV - 1) / DIV;

        logic [PROD_W-1:0] prod;

        assign prod    = PROD_W'(number) * PROD_W'(MULT_W'(MULT));
        assign quot[k] = NUM_W'(prod >> SHIFT);
    end

    // digit k = quot[k] - 10 * quot[k+1], only the low nibble is needed
    for (genvar k = 0; k < NUM_DISPLAYS - 1; k++) begin : g_digit
        logic [DIGIT_W-1:0] tens;

        assign tens      = {quot[k+1][0], 3'b000} + {quot[k+1][2:0], 1'b0};
        assign digits[k] = quot[k][DIGIT_W-1:0] - tens;
    end

    // top digit, the value is at most six digits wide when it is used
    assign digits[NUM_DISPLAYS-1] = quot[NUM_DISPLAYS-1][DIGIT_W-1:0];

endmodule

// ===== rtl/core/ssdw_seg_update.sv =====
// segment registers and the command decode that updates them
module ssdw_seg_update
    import ssdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  ssdw_in_t     item,
    input  ssdw_digits_t digits,
    output ssdw_out_t    result
);

    logic [NUM_DISPLAYS-1:0][SEG_W-1:0] seg_reg;
    logic [NUM_DISPLAYS-1:0][SEG_W-1:0] seg_next;
    logic                               bad;

    // command decode and operand checks
    always_comb
    begin
        seg_next = seg_reg;
        bad      = 1'b0;
        case (item.cmd)
            CMD_CLEAR:
            begin
                for (int k = 0; k < NUM_DISPLAYS; k++)
                begin
                    seg_next[k] = SEG_BLANK;
                end
            end
            CMD_DIGIT:
            begin
                if ((item.position >= 3'(NUM_DISPLAYS)) || (item.digit > BLANK_DIGIT))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    seg_next[item.position] = seg_encode(item.digit);
                end
            end
            CMD_INT:
            begin
                if (item.number > INT_LIMIT)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < NUM_DISPLAYS; k++)
                    begin
                        seg_next[k] = seg_encode(digits[k]);
                    end
                end
            end
            CMD_SCORE:
            begin
                if (item.number > SCORE_LIMIT)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < NUM_DISPLAYS / 2; k++)
                    begin
                        if (item.player)
                        begin
                            seg_next[k + NUM_DISPLAYS / 2] = seg_encode(digits[k]);
                        end
                        else
                        begin
                            seg_next[k] = seg_encode(digits[k]);
                        end
                    end
                end
            end
            CMD_RAW:
            begin
                for (int k = 0; k < NUM_DISPLAYS; k++)
                begin
                    seg_next[NUM_DISPLAYS - 1 - k] = item.raw_patterns[SEG_W*k +: SEG_W];
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // display registers, blank after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DISPLAYS; k++)
            begin
                seg_reg[k] <= SEG_BLANK;
            end
        end
        else if (fire)
        begin
            seg_reg <= seg_next;
        end
    end

    // result shows the registers as they stand after this command
    assign result.seg0        = seg_next[0];
    assign result.seg1        = seg_next[1];
    assign result.seg2        = seg_next[2];
    assign result.seg3        = seg_next[3];
    assign result.seg4        = seg_next[4];
    assign result.seg5        = seg_next[5];
    assign result.bad_operand = bad;

    // clear leaves every display blank
    a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.cmd == CMD_CLEAR) |=> seg_reg == {NUM_DISPLAYS{SEG_BLANK}})
        else $error("clear did not blank all displays");

    // a rejected command or an idle cycle leaves the displays alone
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire || bad |=> seg_reg == $past(seg_reg))
        else $error("displays changed without an accepted command");

    // an in-range integer always splits into decimal digits
    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.cmd == CMD_INT) && !bad |->
            (digits[0] <= 4'd9) && (digits[1] <= 4'd9) && (digits[2] <= 4'd9) &&
            (digits[3] <= 4'd9) && (digits[4] <= 4'd9) && (digits[5] <= 4'd9))
        else $error("integer split produced a non-decimal digit");

endmodule

// ===== rtl/core/seven_segment_display_writer_unit.sv =====
// top level of the six-digit seven-segment display writer
//
// Usage:
//   cmd channel (cmd_valid, cmd_ready, cmd_data) takes one command beat:
//   clear, write digit, write integer, write score or write raw patterns.
//   disp channel (disp_valid, disp_ready, disp_data) returns exactly one
//   beat per command, holding all six active-low segment patterns after
//   the command and a bad_operand flag for a rejected command.
//   A command is registered on acceptance, decoded in one pass (including
//   the binary to decimal split by constant multiplies) and its result is
//   registered: a command passes the input register, then the result
//   register, before its result beat is valid. One command per cycle is
//   sustained while disp_ready stays high; the rate is set by the single result register.
//   When disp_ready is low, one command waits in the input register and
//   cmd_ready drops until the pending result is taken; nothing is lost.
//   Reset blanks all six displays and empties both registers.
module seven_segment_display_writer_unit
    import ssdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  ssdw_in_t  cmd_data,
    output logic      disp_valid,
    input  logic      disp_ready,
    output ssdw_out_t disp_data
);

    ssdw_in_t     cmd_reg;
    logic         cmd_valid_reg;
    ssdw_out_t    disp_reg;
    logic         disp_valid_reg;
    logic         advance;
    ssdw_digits_t digits;
    ssdw_out_t    result;

    // a held command moves on when the result register is free or emptying
    assign advance   = cmd_valid_reg && (!disp_valid_reg || disp_ready);
    assign cmd_ready = !cmd_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_valid && cmd_ready)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd_data;
        end
    end

    ssdw_digit_split u_digit_split (
        .number (cmd_reg.number),
        .digits (digits)
    );

    ssdw_seg_update u_seg_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (cmd_reg),
        .digits (digits),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            disp_valid_reg <= 1'b1;
        end
        else if (disp_ready)
        begin
            disp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            disp_reg <= result;
        end
    end

    assign disp_valid = disp_valid_reg;
    assign disp_data  = disp_reg;

    // input side stalls only behind a result that is not being taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> disp_valid && !disp_ready)
        else $error("command refused without a stalled result");

    // every decoded command leaves a result beat
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> disp_valid)
        else $error("decoded command produced no result beat");

    // a stalled result beat holds steady until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && !disp_ready |=> disp_valid && $stable(disp_data))
        else $error("result beat changed while stalled");

endmodule

// ===== tb/ssdw_display_checker.sv =====
// beat monitor for the display writer: tracks the six displays, predicts each result and compares
module ssdw_display_checker
    import ssdw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_ready,
    input  ssdw_in_t  cmd_data,
    input  logic      disp_valid,
    input  logic      disp_ready,
    input  ssdw_out_t disp_data,
    output int        pending_beats,
    output int        fail_count
);

    typedef logic [NUM_DISPLAYS-1:0][SEG_W-1:0] seg_bank_t;

    localparam int HALF = NUM_DISPLAYS / 2;

    // active-low glyphs for digits 0..9, then blank
    localparam logic [SEG_W-1:0] GLYPH [0:10] = '{
        7'd64, 7'd121, 7'd36, 7'd48, 7'd25, 7'd18, 7'd2, 7'd120, 7'd0, 7'd16, 7'd127
    };

    seg_bank_t shown;
    ssdw_out_t awaited_frames[$];

    // next contents of the displays after one command, and whether it is rejected
    function automatic seg_bank_t apply_command(input ssdw_in_t c, input seg_bank_t cur,
                                                output logic bad);
        seg_bank_t   nxt;
        int unsigned value;
        int unsigned base;
        nxt = cur;
        bad = 1'b0;
        case (c.cmd)
            CMD_CLEAR:
            begin
                for (int k = 0; k < NUM_DISPLAYS; k++)
                    nxt[k] = GLYPH[BLANK_DIGIT];
            end
            CMD_DIGIT:
            begin
                if (c.position >= 3'(NUM_DISPLAYS) || c.digit > BLANK_DIGIT)
                    bad = 1'b1;
                else
                    nxt[c.position] = GLYPH[c.digit];
            end
            CMD_INT:
            begin
                if (c.number > INT_LIMIT)
                    bad = 1'b1;
                else
                begin
                    value = 32'(c.number);
                    for (int k = 0; k < NUM_DISPLAYS; k++)
                    begin
                        nxt[k] = GLYPH[value % 10];
                        value  = value / 10;
                    end
                end
            end
            CMD_SCORE:
            begin
                if (c.number > SCORE_LIMIT)
                    bad = 1'b1;
                else
                begin
                    value = 32'(c.number);
                    base  = c.player ? HALF : 0;
                    for (int k = 0; k < HALF; k++)
                    begin
                        nxt[base + k] = GLYPH[value % 10];
                        value         = value / 10;
                    end
                end
            end
            CMD_RAW:
            begin
                // first pattern in the top bits lands on the lowest display
                for (int k = 0; k < NUM_DISPLAYS; k++)
                    nxt[NUM_DISPLAYS - 1 - k] = c.raw_patterns[SEG_W*k +: SEG_W];
            end
            default:
                bad = 1'b1;
        endcase
        return nxt;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count    = 0;
        pending_beats = 0;
    end

    // compare result beats first, then queue the prediction for a new command beat
    always @(posedge clk or negedge rst_n)
    begin
        ssdw_out_t want;
        seg_bank_t nxt;
        logic      bad;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DISPLAYS; k++)
                shown[k] = GLYPH[BLANK_DIGIT];
            awaited_frames.delete();
            pending_beats <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (disp_valid && disp_ready)
            begin
                if (awaited_frames.size() == 0)
                begin
                    $error("result beat with no command waiting: %h", disp_data);
                    fail_count++;
                end
                else
                begin
                    want = awaited_frames.pop_front();
                    check_field("seg0", 32'(want.seg0), 32'(disp_data.seg0));
                    check_field("seg1", 32'(want.seg1), 32'(disp_data.seg1));
                    check_field("seg2", 32'(want.seg2), 32'(disp_data.seg2));
                    check_field("seg3", 32'(want.seg3), 32'(disp_data.seg3));
                    check_field("seg4", 32'(want.seg4), 32'(disp_data.seg4));
                    check_field("seg5", 32'(want.seg5), 32'(disp_data.seg5));
                    check_field("bad_operand", 32'(want.bad_operand),
                                32'(disp_data.bad_operand));
                end
            end
            // command beat updates the tracked displays
            if (cmd_valid && cmd_ready)
            begin
                nxt   = apply_command(cmd_data, shown, bad);
                shown = nxt;
                want.seg0        = nxt[0];
                want.seg1        = nxt[1];
                want.seg2        = nxt[2];
                want.seg3        = nxt[3];
                want.seg4        = nxt[4];
                want.seg5        = nxt[5];
                want.bad_operand = bad;
                awaited_frames.push_back(want);
            end
            pending_beats <= awaited_frames.size();
        end
    end

    // predictions never answered
    final
    begin
        if (awaited_frames.size() != 0)
            $error("%0d result beats never arrived", awaited_frames.size());
    end

endmodule

// ===== tb/seven_segment_display_writer_unit_tb.sv =====
// top of the display writer testbench: clock, reset, command stimulus, result backpressure, verdict
module seven_segment_display_writer_unit_tb;
    import ssdw_pkg::*;

    localparam int RANDOM_BEATS = 1100;
    localparam int QUIET_BEATS  = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    ssdw_in_t  cmd_data;
    logic      disp_valid;
    logic      disp_ready;
    ssdw_out_t disp_data;
    int        pending_beats;
    int        fail_count;
    int        cycle_count;
    bit        src_idles;
    bit        sink_idles;

    seven_segment_display_writer_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .disp_valid (disp_valid),
        .disp_ready (disp_ready),
        .disp_data  (disp_data)
    );

    ssdw_display_checker u_display_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_data      (cmd_data),
        .disp_valid    (disp_valid),
        .disp_ready    (disp_ready),
        .disp_data     (disp_data),
        .pending_beats (pending_beats),
        .fail_count    (fail_count)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("seven_segment_display_writer_unit_tb failed");
            $finish;
        end
    end

    // every field random, unused ones included
    function automatic ssdw_in_t with_op(input logic [2:0] op);
        ssdw_in_t c;
        c.cmd          = op;
        c.position     = 3'($urandom_range(0, 7));
        c.digit        = 4'($urandom_range(0, 15));
        c.number       = 20'($urandom_range(0, 20'hFFFFF));
        c.player       = 1'($urandom_range(0, 1));
        c.raw_patterns = {10'($urandom()), 32'($urandom())};
        return c;
    endfunction

    // mostly legal operands, with a share of rejected ones and unknown commands
    function automatic ssdw_in_t random_command();
        ssdw_in_t    c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c = with_op(CMD_CLEAR);
        else if (pick < 30)
        begin
            c = with_op(CMD_DIGIT);
            if ($urandom_range(0, 99) < 85)
                c.position = 3'($urandom_range(0, NUM_DISPLAYS - 1));
            if ($urandom_range(0, 99) < 85)
                c.digit = 4'($urandom_range(0, BLANK_DIGIT));
        end
        else if (pick < 55)
        begin
            c = with_op(CMD_INT);
            if ($urandom_range(0, 99) < 90)
                c.number = 20'($urandom_range(0, INT_LIMIT));
        end
        else if (pick < 80)
        begin
            c = with_op(CMD_SCORE);
            if ($urandom_range(0, 99) < 85)
                c.number = 20'($urandom_range(0, SCORE_LIMIT));
            else if ($urandom_range(0, 1) == 0)
                c.number = 20'($urandom_range(SCORE_LIMIT, SCORE_LIMIT + 1));
        end
        else if (pick < 95)
            c = with_op(CMD_RAW);
        else
            c = with_op(3'($urandom_range(CMD_RAW + 1, 7)));
        return c;
    endfunction

    // one command beat, with an occasional idle burst ahead of it
    task automatic issue_command(input ssdw_in_t c);
        if (src_idles && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do @(posedge clk); while (!cmd_ready);
    endtask

    // hold off commands until every result beat is back
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    // result side: ready with random stall bursts
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_idles && $urandom_range(0, 2) == 0)
            begin
                disp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            disp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // command stimulus and verdict
    initial
    begin
        ssdw_in_t c;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd_data    = '0;
        disp_ready  = 1'b0;
        cycle_count = 0;
        src_idles   = 1'b1;
        sink_idles  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clear and single digits, edges of position and digit
        issue_command(with_op(CMD_CLEAR));
        c = with_op(CMD_DIGIT); c.position = 3'd0; c.digit = 4'd0; issue_command(c);
        c = with_op(CMD_DIGIT); c.position = 3'd5; c.digit = 4'd9; issue_command(c);
        c = with_op(CMD_DIGIT); c.position = 3'd3; c.digit = BLANK_DIGIT; issue_command(c);
        c = with_op(CMD_DIGIT); c.position = 3'd6; c.digit = 4'd1; issue_command(c);
        c = with_op(CMD_DIGIT); c.position = 3'd7; c.digit = 4'd15; issue_command(c);
        c = with_op(CMD_DIGIT); c.position = 3'd2; c.digit = 4'(BLANK_DIGIT + 1);
        issue_command(c);

        // integer at and past its limits, leading zeros
        c = with_op(CMD_INT); c.number = 20'd0; issue_command(c);
        c = with_op(CMD_INT); c.number = INT_LIMIT; issue_command(c);
        c = with_op(CMD_INT); c.number = 20'(INT_LIMIT + 1); issue_command(c);
        c = with_op(CMD_INT); c.number = 20'hFFFFF; issue_command(c);
        c = with_op(CMD_INT); c.number = 20'd123456; issue_command(c);
        c = with_op(CMD_INT); c.number = 20'd42; issue_command(c);

        // scores on both halves, other half left alone
        c = with_op(CMD_SCORE); c.number = 20'd0; c.player = 1'b0; issue_command(c);
        c = with_op(CMD_SCORE); c.number = SCORE_LIMIT; c.player = 1'b1; issue_command(c);
        c = with_op(CMD_SCORE); c.number = 20'(SCORE_LIMIT + 1); c.player = 1'b0;
        issue_command(c);
        c = with_op(CMD_SCORE); c.number = 20'hFFFFF; c.player = 1'b1; issue_command(c);
        c = with_op(CMD_SCORE); c.number = 20'd7; c.player = 1'b1; issue_command(c);

        // raw patterns: all ones, all zeros, distinct per display
        c = with_op(CMD_RAW); c.raw_patterns = '1; issue_command(c);
        c = with_op(CMD_RAW); c.raw_patterns = '0; issue_command(c);
        c = with_op(CMD_RAW);
        c.raw_patterns = {7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd96};
        issue_command(c);

        // unknown commands leave everything as it is
        issue_command(with_op(3'(CMD_RAW + 1)));
        issue_command(with_op(3'd6));
        issue_command(with_op(3'd7));
        issue_command(with_op(CMD_CLEAR));
        wait_for_results();

        // random commands, one full drain halfway, no idling at the tail
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
                wait_for_results();
            if (n == RANDOM_BEATS - QUIET_BEATS)
            begin
                src_idles  = 1'b0;
                sink_idles = 1'b0;
            end
            issue_command(random_command());
        end
        wait_for_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("seven_segment_display_writer_unit_tb passed");
        else
            $display("seven_segment_display_writer_unit_tb failed");
        $finish;
    end

endmodule
